/* hw/rtl/frame_smac_dhcp_classifier_assert.svh */
// Assertion macros for the frame classifier blocks.
// Depends on nothing; the including module must have clk_i and rst_ni.
`ifndef FRAME_SMAC_DHCP_CLASSIFIER_ASSERT_SVH
`define FRAME_SMAC_DHCP_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define FSDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Next-cycle implication, disabled while reset is low
`define FSDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) \
    else $error(msg);

`endif

/* hw/rtl/fsdc_pkg.sv */
// Shared types and constants for the frame source-MAC / DHCP classifier.
// No dependencies.
package fsdc_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgRouterPrefix = 2'd0,
    CfgSwitchMac    = 2'd1,
    CfgWcMacFirst   = 2'd2,
    CfgWcMacSecond  = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 48;

  // Source MAC classes
  typedef enum logic [1:0] {
    SmacNone   = 2'd0,
    SmacRouter = 2'd1,
    SmacSwitch = 2'd2,
    SmacWc     = 2'd3
  } smac_class_e;

  // Register reset values
  localparam logic [31:0] RouterPrefixRst = 32'd3089623878;
  localparam logic [47:0] SwitchMacRst    = 48'd193760310615326;
  localparam logic [47:0] WcMacFirstRst   = 48'd82594236066;
  localparam logic [47:0] WcMacSecondRst  = 48'd963354431846;

  // Frame layout
  localparam logic [6:0]  EthHdrLen   = 7'd14;
  localparam logic [6:0]  VlanTagLen  = 7'd4;
  localparam logic [6:0]  PosSmacLo   = 7'd6;
  localparam logic [6:0]  PosSmacHi   = 7'd11;
  localparam logic [6:0]  PosEtypeHi  = 7'd12;
  localparam logic [6:0]  PosEtypeLo  = 7'd13;
  localparam logic [6:0]  PosVlanHi   = 7'd14;
  localparam logic [6:0]  PosVlanLo   = 7'd15;
  localparam logic [6:0]  PosInnerHi  = 7'd16;
  localparam logic [6:0]  PosInnerLo  = 7'd17;
  localparam logic [6:0]  IpProtoOfs  = 7'd9;
  localparam logic [7:0]  IpNeedLen   = 8'd10;
  localparam logic [7:0]  PortNeedLen = 8'd2;
  localparam logic [6:0]  PosMax      = 7'd127;

  localparam logic [15:0] EtVlan   = 16'h8100;
  localparam logic [15:0] EtIpv4   = 16'h0800;
  localparam logic [7:0]  ProtoUdp = 8'd17;
  localparam logic [15:0] PortA    = 16'd67;
  localparam logic [15:0] PortB    = 16'd68;
  localparam logic [3:0]  IhlMin   = 4'd5;

  // Bit positions in the match flags
  localparam int unsigned FlagIpv4 = 0;
  localparam int unsigned FlagUdp  = 1;
  localparam int unsigned FlagPort = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
  } in_word_t;

  typedef struct packed {
    smac_class_e smac_class;
    logic        has_vlan;
    logic [11:0] vlan_number;
    logic        is_dhcp;
    logic        truncated;
  } out_word_t;

  typedef struct packed {
    logic [31:0] router_mac_prefix;
    logic [47:0] switch_mac;
    logic [47:0] wc_mac_first;
    logic [47:0] wc_mac_second;
  } cfg_t;

  // Input register contents handed to the parser
  typedef struct packed {
    logic     vld;
    in_word_t word;
  } stage_t;

endpackage

/* hw/rtl/fsdc_in_reg.sv */
// Input register: takes one frame byte per cycle from the upstream channel
// while the parser takes the held byte. Depends on fsdc_pkg.
module fsdc_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fsdc_pkg::in_word_t in_word_i,
  input  logic              take_i,
  output fsdc_pkg::stage_t  stg_o
);
  import fsdc_pkg::*;

  logic     vld_q;
  in_word_t word_q;

  // free when empty or when the held word moves on this cycle
  assign in_ready_o = !vld_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= in_word_i;
    end
  end

  assign stg_o = '{vld: vld_q, word: word_q};

endmodule

/* hw/rtl/fsdc_hdr_parse.sv */
// Header parser: per-frame field capture and result build on the last byte.
// Depends on fsdc_pkg and frame_smac_dhcp_classifier_assert.svh.
module fsdc_hdr_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fsdc_pkg::stage_t    stg_i,
  input  fsdc_pkg::cfg_t      cfg_i,
  input  logic                out_free_i,
  output logic                take_o,
  output logic                res_vld_o,
  output fsdc_pkg::out_word_t res_o
);
  import fsdc_pkg::*;
  `include "frame_smac_dhcp_classifier_assert.svh"

  logic [6:0]  pos_q, pos_d;
  logic [47:0] smac_q, smac_d;
  logic [15:0] etype_q, etype_d;
  logic        tagged_q, tagged_d;
  logic [11:0] vlan_q, vlan_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [2:0]  flags_q, flags_d;
  logic [15:0] port_q, port_d;

  logic [7:0]  b;
  logic        last;
  logic [6:0]  p;
  logic [6:0]  l3;
  logic [6:0]  port_pos;
  logic        ihl_ok;
  logic [7:0]  len;
  logic [7:0]  need;
  logic        trunc;
  smac_class_e cls;

  assign b    = stg_i.word.data_byte;
  assign last = stg_i.word.end_of_frame;
  assign p    = pos_q;

  // a last byte waits until the result register can take it
  assign take_o    = stg_i.vld && (!last || out_free_i);
  assign res_vld_o = take_o && last;

  // L3 start and UDP source port position, from the state before this byte
  assign l3       = tagged_q ? (EthHdrLen + VlanTagLen) : EthHdrLen;
  assign port_pos = l3 + {1'b0, ihl_q, 2'b00};
  assign ihl_ok   = (ihl_q >= IhlMin);

  // Field capture for the current byte
  always_comb begin
    smac_d   = smac_q;
    etype_d  = etype_q;
    vlan_d   = vlan_q;
    ihl_d    = ihl_q;
    flags_d  = flags_q;
    port_d   = port_q;

    if (p >= PosSmacLo && p <= PosSmacHi) begin
      smac_d = {smac_q[39:0], b};
    end
    if (p == PosEtypeHi || p == PosEtypeLo ||
        (tagged_q && (p == PosInnerHi || p == PosInnerLo))) begin
      etype_d = {etype_q[7:0], b};
    end
    tagged_d = tagged_q || (p == PosEtypeLo && etype_d == EtVlan);
    if (tagged_q && (p == PosVlanHi || p == PosVlanLo)) begin
      vlan_d = {vlan_q[3:0], b};
    end
    if (p == l3 && etype_q == EtIpv4) begin
      flags_d[FlagIpv4] = 1'b1;
      ihl_d             = b[3:0];
    end
    if (flags_q[FlagIpv4] && p == l3 + IpProtoOfs && b == ProtoUdp) begin
      flags_d[FlagUdp] = 1'b1;
    end
    if (flags_q[FlagUdp] && ihl_ok) begin
      if (p == port_pos || p == port_pos + 7'd1) begin
        port_d = {port_q[7:0], b};
      end
      if (p == port_pos + 7'd1) begin
        flags_d[FlagPort] = 1'b1;
      end
    end
  end

  // Length check against the bytes the headers need
  always_comb begin
    len  = {1'b0, p} + 8'd1;
    need = {1'b0, l3};
    if (flags_d[FlagIpv4]) begin
      need = {1'b0, l3} + IpNeedLen;
    end
    if (flags_d[FlagUdp] && ihl_ok) begin
      need = {1'b0, port_pos} + PortNeedLen;
    end
    trunc = (len < need);
  end

  // Source MAC class, router prefix first
  always_comb begin
    cls = SmacNone;
    if (p >= PosSmacHi) begin
      if (smac_d[47:16] == cfg_i.router_mac_prefix) begin
        cls = SmacRouter;
      end else if (smac_d == cfg_i.switch_mac) begin
        cls = SmacSwitch;
      end else if (smac_d == cfg_i.wc_mac_first || smac_d == cfg_i.wc_mac_second) begin
        cls = SmacWc;
      end
    end
  end

  always_comb begin
    res_o.smac_class  = cls;
    res_o.has_vlan    = tagged_d;
    res_o.vlan_number = (tagged_d && p >= PosVlanLo) ? vlan_d : 12'd0;
    res_o.is_dhcp     = !trunc && flags_d[FlagPort] && (port_d == PortA || port_d == PortB);
    res_o.truncated   = trunc;
  end

  // Position saturates; state clears after the last byte
  assign pos_d = (pos_q == PosMax) ? pos_q : pos_q + 7'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      smac_q   <= '0;
      etype_q  <= '0;
      tagged_q <= 1'b0;
      vlan_q   <= '0;
      ihl_q    <= '0;
      flags_q  <= '0;
      port_q   <= '0;
    end else if (take_o) begin
      if (last) begin
        pos_q    <= '0;
        smac_q   <= '0;
        etype_q  <= '0;
        tagged_q <= 1'b0;
        vlan_q   <= '0;
        ihl_q    <= '0;
        flags_q  <= '0;
        port_q   <= '0;
      end else begin
        pos_q    <= pos_d;
        smac_q   <= smac_d;
        etype_q  <= etype_d;
        tagged_q <= tagged_d;
        vlan_q   <= vlan_d;
        ihl_q    <= ihl_d;
        flags_q  <= flags_d;
        port_q   <= port_d;
      end
    end
  end

  // Checks
  `FSDC_ASSERT(a_dhcp_not_trunc, res_vld_o |-> !(res_o.is_dhcp && res_o.truncated), "DHCP flagged on truncated frame")
  `FSDC_ASSERT(a_vid_needs_tag, (res_vld_o && res_o.vlan_number != 12'd0) |-> res_o.has_vlan, "VLAN id without tag")
  `FSDC_ASSERT_NEXT(a_clear_after_last, (take_o && last), (pos_q == 7'd0 && flags_q == 3'd0), "frame state not cleared")
  `FSDC_ASSERT_NEXT(a_pos_step, (take_o && !last && pos_q != PosMax), (pos_q == $past(pos_q) + 7'd1), "byte position did not advance")

endmodule

/* hw/rtl/fsdc_out_reg.sv */
// Result register: holds one classification word until downstream takes it.
// Depends on fsdc_pkg.
module fsdc_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_vld_i,
  input  fsdc_pkg::out_word_t res_i,
  output logic                out_free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fsdc_pkg::out_word_t out_word_o
);
  import fsdc_pkg::*;

  logic      vld_q;
  out_word_t word_q;

  // can load when empty or being emptied this cycle
  assign out_free_o = !vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (res_vld_i) begin
      vld_q <= 1'b1;
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld_i) begin
      word_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_word_o  = word_q;

endmodule

/* hw/rtl/frame_smac_dhcp_classifier.sv */
// Frame classifier top level: configuration registers and the three stages.
// Depends on fsdc_pkg, fsdc_in_reg, fsdc_hdr_parse, fsdc_out_reg.
//
// Usage:
//   in channel  : one frame byte per word (data_byte, end_of_frame), starting
//                 at the first destination MAC byte; valid/ready handshake.
//   out channel : one word per frame, issued for the byte marked end_of_frame,
//                 carrying source MAC class, VLAN tag and id, DHCP and
//                 truncation flags; valid/ready handshake.
//   cfg port    : cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//                 (router prefix, switch MAC, two WC MACs); write only
//                 while no frame is in flight.
// Throughput is one byte per cycle unless a last byte waits for a free result
// register: the input register, a single pass of compare-and-shift logic in
// the parser, and the result register, which drives out_valid_o. When the
// receiver stalls, the result stays held and the next frame's bytes keep
// flowing in; only a second last byte waits, which then back-pressures
// in_ready_o. Reset clears all frame state and loads the default MACs.
module frame_smac_dhcp_classifier (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  fsdc_pkg::in_word_t                 in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output fsdc_pkg::out_word_t                out_word_o,
  input  logic                               cfg_we_i,
  input  logic [fsdc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [fsdc_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import fsdc_pkg::*;

  cfg_t      cfg_q;
  stage_t    stg;
  logic      take;
  logic      out_free;
  logic      res_vld;
  out_word_t res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.router_mac_prefix <= RouterPrefixRst;
      cfg_q.switch_mac        <= SwitchMacRst;
      cfg_q.wc_mac_first      <= WcMacFirstRst;
      cfg_q.wc_mac_second     <= WcMacSecondRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgRouterPrefix: cfg_q.router_mac_prefix <= cfg_wdata_i[31:0];
        CfgSwitchMac:    cfg_q.switch_mac        <= cfg_wdata_i;
        CfgWcMacFirst:   cfg_q.wc_mac_first      <= cfg_wdata_i;
        CfgWcMacSecond:  cfg_q.wc_mac_second     <= cfg_wdata_i;
      endcase
    end
  end

  fsdc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .take_i     (take),
    .stg_o      (stg)
  );

  fsdc_hdr_parse u_hdr_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stg_i      (stg),
    .cfg_i      (cfg_q),
    .out_free_i (out_free),
    .take_o     (take),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  fsdc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

/* bench/tb_top.sv */
// Self-checking bench for frame_smac_dhcp_classifier: byte stream in, one word per frame out.
// Depends on fsdc_pkg and the classifier RTL; holds its own frame predictor and scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fsdc_pkg::*;

  localparam int unsigned PhaseBytes = 240;
  localparam int unsigned HoldCycles = 300;

  // Predictor of the classifier plus the queue of words still owed by the block
  class frame_result_board;
    cfg_t        regs;
    logic [6:0]  pos;
    logic [47:0] smac;
    logic [15:0] etype;
    logic        vlan_tag;
    logic [11:0] vid;
    logic [3:0]  ihl;
    logic [2:0]  flags;
    logic [15:0] port;
    out_word_t   pending_results[$];
    int unsigned errors;

    function new();
      regs.router_mac_prefix = RouterPrefixRst;
      regs.switch_mac        = SwitchMacRst;
      regs.wc_mac_first      = WcMacFirstRst;
      regs.wc_mac_second     = WcMacSecondRst;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos = '0; smac = '0; etype = '0; vlan_tag = 1'b0;
      vid = '0; ihl = '0; flags = '0; port = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [47:0] d);
      case (idx)
        CfgRouterPrefix: regs.router_mac_prefix = d[31:0];
        CfgSwitchMac:    regs.switch_mac        = d;
        CfgWcMacFirst:   regs.wc_mac_first      = d;
        CfgWcMacSecond:  regs.wc_mac_second     = d;
        default: ;
      endcase
    endfunction

    function int unsigned pending_count();
      return pending_results.size();
    endfunction

    // One accepted byte; on the last byte of a frame an expected word is queued
    function void note_byte(in_word_t w);
      int unsigned p, l3, q, len, need;
      logic [7:0]  b;
      out_word_t   exp;
      b  = w.data_byte;
      p  = pos;
      l3 = vlan_tag ? EthHdrLen + VlanTagLen : EthHdrLen;

      if (p >= PosSmacLo && p <= PosSmacHi) smac = {smac[39:0], b};
      if (p == PosEtypeHi || p == PosEtypeLo) etype = {etype[7:0], b};
      if (p == PosEtypeLo && etype == EtVlan) vlan_tag = 1'b1;
      if (vlan_tag && (p == PosVlanHi || p == PosVlanLo)) vid = {vid[3:0], b};
      if (vlan_tag && (p == PosInnerHi || p == PosInnerLo)) etype = {etype[7:0], b};
      if (p == l3 && etype == EtIpv4) begin
        flags[FlagIpv4] = 1'b1;
        ihl = b[3:0];
      end
      if (flags[FlagIpv4] && p == l3 + IpProtoOfs && b == ProtoUdp) flags[FlagUdp] = 1'b1;
      // source port sits right after the IP header, only for a sane IHL
      if (flags[FlagUdp] && ihl >= IhlMin) begin
        q = l3 + 4 * ihl;
        if (p == q || p == q + 1) port = {port[7:0], b};
        if (p == q + 1) flags[FlagPort] = 1'b1;
      end
      if (pos != PosMax) pos = pos + 1'b1;
      if (!w.end_of_frame) return;

      len  = p + 1;
      need = l3;
      if (flags[FlagIpv4]) need = l3 + IpNeedLen;
      if (flags[FlagUdp] && ihl >= IhlMin) need = l3 + 4 * ihl + PortNeedLen;
      exp.truncated  = (len < need);
      exp.smac_class = SmacNone;
      if (len > PosSmacHi) begin
        if (smac[47:16] == regs.router_mac_prefix) exp.smac_class = SmacRouter;
        else if (smac == regs.switch_mac) exp.smac_class = SmacSwitch;
        else if (smac == regs.wc_mac_first || smac == regs.wc_mac_second)
          exp.smac_class = SmacWc;
      end
      exp.has_vlan    = vlan_tag;
      exp.vlan_number = (vlan_tag && len > PosVlanLo) ? vid : 12'd0;
      exp.is_dhcp     = !exp.truncated && flags[FlagPort] && (port == PortA || port == PortB);
      pending_results.push_back(exp);
      clear_frame();
    endfunction

    // One accepted result word against the oldest expectation
    function void check_result(out_word_t got);
      out_word_t exp;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %p", got);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.smac_class !== exp.smac_class) begin
        $error("smac_class: expected %0d, got %0d", exp.smac_class, got.smac_class);
        errors++;
      end
      if (got.has_vlan !== exp.has_vlan) begin
        $error("has_vlan: expected %0d, got %0d", exp.has_vlan, got.has_vlan);
        errors++;
      end
      if (got.vlan_number !== exp.vlan_number) begin
        $error("vlan_number: expected %0d, got %0d", exp.vlan_number, got.vlan_number);
        errors++;
      end
      if (got.is_dhcp !== exp.is_dhcp) begin
        $error("is_dhcp: expected %0d, got %0d", exp.is_dhcp, got.is_dhcp);
        errors++;
      end
      if (got.truncated !== exp.truncated) begin
        $error("truncated: expected %0d, got %0d", exp.truncated, got.truncated);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_word_t            in_word_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_word_t           out_word_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  frame_result_board sb;
  logic [7:0]        frame_q[$];
  int unsigned       tx_idle_pct;
  int unsigned       rx_stall_pct;
  bit                rx_hold_req;

  frame_smac_dhcp_classifier u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Handshake monitors, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_byte(in_word_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_word_o);
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        hold_left   = HoldCycles;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Builds the next frame into frame_q, mostly well-formed headers
  function automatic void make_frame(bit short_only);
    logic [47:0] src;
    logic [15:0] etype, port;
    int unsigned sel, ihl, hdr_len, cut, i;
    frame_q.delete();
    // noise, or tiny frames while the receiver holds off
    if (short_only || $urandom_range(9) == 0) begin
      repeat ($urandom_range(short_only ? 6 : 40, 1)) frame_q.push_back(8'($urandom));
      return;
    end
    repeat (6) frame_q.push_back(8'($urandom));
    sel = $urandom_range(5);
    case (sel)
      0:       src = {sb.regs.router_mac_prefix, 16'($urandom)};
      1:       src = sb.regs.switch_mac;
      2:       src = sb.regs.wc_mac_first;
      3:       src = sb.regs.wc_mac_second;
      default: src = rand48();
    endcase
    for (i = 0; i < 6; i++) frame_q.push_back(src[47 - 8 * i -: 8]);
    if ($urandom_range(2) == 0) begin
      frame_q.push_back(EtVlan[15:8]);
      frame_q.push_back(EtVlan[7:0]);
      frame_q.push_back(8'($urandom));
      frame_q.push_back(8'($urandom));
    end
    sel   = $urandom_range(9);
    etype = (sel < 8) ? EtIpv4 : (sel == 8) ? EtVlan : 16'($urandom);
    frame_q.push_back(etype[15:8]);
    frame_q.push_back(etype[7:0]);
    // IP header: IHL mostly 5, sometimes too small or with options
    sel = $urandom_range(9);
    ihl = (sel < 7) ? 5 : (sel < 9) ? $urandom_range(4) : $urandom_range(15, 6);
    frame_q.push_back({4'($urandom), 4'(ihl)});
    repeat (8) frame_q.push_back(8'($urandom));
    frame_q.push_back(($urandom_range(4) != 0) ? ProtoUdp : 8'($urandom));
    hdr_len = (ihl >= IhlMin) ? 4 * ihl : 20;
    repeat (hdr_len - 10) frame_q.push_back(8'($urandom));
    sel  = $urandom_range(3);
    port = (sel == 0) ? PortA : (sel == 1) ? PortB :
           (sel == 2) ? 16'($urandom_range(71, 64)) : 16'($urandom);
    frame_q.push_back(port[15:8]);
    frame_q.push_back(port[7:0]);
    repeat ($urandom_range(12)) frame_q.push_back(8'($urandom));
    // cut short, or stretch past the position counter's ceiling
    sel = $urandom_range(19);
    if (sel < 5) begin
      cut     = $urandom_range(frame_q.size(), 1);
      frame_q = frame_q[0:cut - 1];
    end else if (sel == 5) begin
      cut = $urandom_range(150, 126);
      while (frame_q.size() < cut) frame_q.push_back(8'($urandom));
    end
  endfunction

  // Offers one word and waits for its acceptance
  task automatic send_byte(logic [7:0] b, logic eof);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i  = '{data_byte: b, end_of_frame: eof};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [47:0] d);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = d;
    @(posedge clk_i);
    sb.set_reg(idx, d);
  endtask

  // Upper bits of the prefix word are junk and must be ignored
  task automatic load_regs(logic [31:0] prefix, logic [47:0] sw, logic [47:0] wc1,
                           logic [47:0] wc2);
    write_reg(CfgRouterPrefix, {16'($urandom), prefix});
    write_reg(CfgSwitchMac, sw);
    write_reg(CfgWcMacFirst, wc1);
    write_reg(CfgWcMacSecond, wc2);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // One traffic phase, ending with the block drained
  task automatic run_phase(int unsigned tx_pct, int unsigned rx_pct, bit pressure);
    int unsigned sent;
    sent         = 0;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    if (pressure) begin
      rx_hold_req = 1'b1;
      repeat (40) begin
        make_frame(1'b1);
        sent += frame_q.size();
        send_frame();
      end
    end
    while (sent < PhaseBytes) begin
      make_frame(1'b0);
      sent += frame_q.size();
      send_frame();
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] pfx;
    logic [47:0] wc;
    sb           = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CfgRouterPrefix;
    cfg_wdata_i  = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_req  = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: single-byte frame, then source MAC only for switch and router
    frame_q = '{8'hFF};
    send_frame();
    frame_q.delete();
    repeat (6) frame_q.push_back(8'h00);
    for (int i = 0; i < 6; i++) frame_q.push_back(sb.regs.switch_mac[47 - 8 * i -: 8]);
    send_frame();
    frame_q.delete();
    repeat (6) frame_q.push_back(8'hFF);
    for (int i = 0; i < 4; i++)
      frame_q.push_back(sb.regs.router_mac_prefix[31 - 8 * i -: 8]);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    send_frame();

    run_phase(0, 0, 1'b0);
    load_regs('0, '0, '0, '0);
    run_phase(76, 0, 1'b0);
    load_regs('1, '1, '1, '1);
    run_phase(0, 76, 1'b0);
    // switch MAC shadowed by the router prefix, both WC entries equal
    pfx = $urandom;
    wc  = rand48();
    load_regs(pfx, {pfx, 16'($urandom)}, wc, wc);
    run_phase(34, 34, 1'b0);
    load_regs($urandom, rand48(), rand48(), rand48());
    run_phase(0, 0, 1'b1);
    load_regs($urandom, rand48(), rand48(), rand48());
    run_phase(34, 34, 1'b0);

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
